### sv/pss_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// Depends on nothing; pss_front, pss_back and the top level refer to it by scoped names.
package pss_pkg;

  localparam int MaxProcesses = 16;
  localparam int QueueDepth   = 2;

  localparam int ArrW   = 12;
  localparam int BurW   = 12;
  localparam int PriW   = 8;
  localparam int NumW   = 5;
  localparam int WaitW  = 16;
  localparam int TurnW  = 17;
  localparam int TWaitW = 20;
  localparam int TTurnW = 21;

  localparam int MaxWait  = 65535;
  localparam int MaxTurn  = 131071;
  localparam int MaxTWait = 1048575;
  localparam int MaxTTurn = 2097151;

  typedef struct packed {
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
    logic [BurW-1:0] remaining;
  } job_t;

  typedef struct packed {
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
    logic            store;
    logic            last;
  } load_t;

  typedef struct packed {
    logic [NumW-1:0]   job_number;
    logic [WaitW-1:0]  waiting;
    logic [TurnW-1:0]  turnaround;
    logic [TWaitW-1:0] total_waiting;
    logic [TTurnW-1:0] total_turnaround;
    logic              last;
  } result_t;

endpackage

### sv/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pss_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/pss_fifo.sv
// Small register queue with full and empty flags.
// Depends on nothing; used between front and back and on the result side.
module pss_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/pss_front.sv
// Load front end: takes job items, fixes a zero burst and drops jobs past capacity.
// Depends on pss_pkg; feeds the queue in front of pss_back.
module pss_front #(
  parameter int MaxJobs = pss_pkg::MaxProcesses
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [pss_pkg::ArrW-1:0]  arrival_i,
  input  logic [pss_pkg::BurW-1:0]  burst_i,
  input  logic [pss_pkg::PriW-1:0]  prio_i,
  input  logic                      last_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output pss_pkg::load_t            q_data_o
);

  localparam int CntW = $clog2(MaxJobs + 1);

  logic [CntW-1:0] load_cnt_q, load_cnt_d;
  logic            accept, store;

  assign accept = push_i && !q_full_i;
  assign store  = (load_cnt_q != CntW'(MaxJobs));

  always_comb begin
    q_data_o.arrival = arrival_i;
    q_data_o.burst   = (burst_i == '0) ? pss_pkg::BurW'(1) : burst_i;
    q_data_o.prio    = prio_i;
    q_data_o.store   = store;
    q_data_o.last    = last_i;
    q_push_o         = accept && (store || last_i);
    load_cnt_d       = load_cnt_q;
    if (accept) begin
      if (last_i) begin
        load_cnt_d = '0;
      end else if (store) begin
        load_cnt_d = load_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
    end
  end

endmodule

### sv/pss_back.sv
// Back end: stores jobs, runs the event-driven schedule over the job RAM, emits results.
// Depends on pss_pkg and pss_ram.
module pss_back #(
  parameter int MaxJobs = pss_pkg::MaxProcesses
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pss_pkg::load_t   ld_data_i,
  input  logic             ld_empty_i,
  output logic             ld_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output pss_pkg::result_t res_data_o
);

  localparam int IdxW  = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int CntW  = $clog2(MaxJobs + 1);
  localparam int TickW = $clog2((MaxJobs + 1) * (1 << pss_pkg::ArrW));
  localparam int JobW  = $bits(pss_pkg::job_t);
  localparam int RamW  = TickW + JobW;
  localparam int SatW  = (TickW > pss_pkg::TTurnW) ? TickW : pss_pkg::TTurnW;
  localparam int SumW  = SatW + 1;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_OUT_RD = 3'd3;
  localparam logic [2:0] S_OUT_WR = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [CntW-1:0]            job_cnt_q, job_cnt_d, done_q, done_d;
  logic [CntW-1:0]            issue_q, issue_d, out_idx_q, out_idx_d;
  logic [TickW-1:0]           tick_q, tick_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]            rd_tag_q, rd_tag_d;
  logic                       found_q, found_d, nxt_vld_q, nxt_vld_d;
  logic [IdxW-1:0]            best_idx_q, best_idx_d;
  pss_pkg::job_t              best_q, best_d;
  logic [pss_pkg::ArrW-1:0]   nxt_arr_q, nxt_arr_d;
  logic [pss_pkg::TWaitW-1:0] twait_q, twait_d;
  logic [pss_pkg::TTurnW-1:0] tturn_q, tturn_d;

  logic                       we;
  logic [IdxW-1:0]            waddr, raddr;
  logic [RamW-1:0]            wdata, rdata;
  pss_pkg::job_t              rd_job, ld_job, upd_job;
  logic [TickW-1:0]           rd_fin;

  logic                       live, future;
  logic [TickW-1:0]           gap, tick_run;
  logic [pss_pkg::BurW-1:0]   run, new_rem;
  logic [TickW-1:0]           turn, wait_t;
  logic [SatW-1:0]            turn_x, wait_x, tw_in, tt_in;
  logic [SumW-1:0]            tw_sum, tt_sum;
  logic [CntW-1:0]            num;

  pss_ram #(
    .Width (RamW),
    .Depth (MaxJobs)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_job = pss_pkg::job_t'(rdata[JobW-1:0]);
  assign rd_fin = rdata[RamW-1 -: TickW];

  assign ld_job.arrival   = ld_data_i.arrival;
  assign ld_job.burst     = ld_data_i.burst;
  assign ld_job.prio      = ld_data_i.prio;
  assign ld_job.remaining = ld_data_i.burst;

  assign live   = (rd_job.remaining != '0);
  assign future = (TickW'(rd_job.arrival) > tick_q);

  assign gap      = TickW'(nxt_arr_q) - tick_q;
  assign run      = (nxt_vld_q && gap < TickW'(best_q.remaining)) ?
                    gap[pss_pkg::BurW-1:0] : best_q.remaining;
  assign new_rem  = best_q.remaining - run;
  assign tick_run = tick_q + TickW'(run);

  always_comb begin
    upd_job           = best_q;
    upd_job.remaining = new_rem;
  end

  assign turn   = rd_fin - TickW'(rd_job.arrival);
  assign wait_t = turn - TickW'(rd_job.burst);
  assign turn_x = SatW'(turn);
  assign wait_x = SatW'(wait_t);
  assign tw_in  = (wait_x > SatW'(pss_pkg::MaxTWait)) ? SatW'(pss_pkg::MaxTWait) : wait_x;
  assign tt_in  = (turn_x > SatW'(pss_pkg::MaxTTurn)) ? SatW'(pss_pkg::MaxTTurn) : turn_x;
  assign tw_sum = SumW'(twait_q) + SumW'(tw_in);
  assign tt_sum = SumW'(tturn_q) + SumW'(tt_in);
  assign num    = out_idx_q + 1'b1;

  always_comb begin
    res_data_o.job_number = pss_pkg::NumW'(num);
    res_data_o.waiting    = (wait_x > SatW'(pss_pkg::MaxWait)) ?
                            pss_pkg::WaitW'(pss_pkg::MaxWait) : wait_x[pss_pkg::WaitW-1:0];
    res_data_o.turnaround = (turn_x > SatW'(pss_pkg::MaxTurn)) ?
                            pss_pkg::TurnW'(pss_pkg::MaxTurn) : turn_x[pss_pkg::TurnW-1:0];
    res_data_o.total_waiting    = twait_d;
    res_data_o.total_turnaround = tturn_d;
    res_data_o.last             = (num == job_cnt_q);
  end

  assign raddr = (state_q == S_SCAN) ? issue_q[IdxW-1:0] : out_idx_q[IdxW-1:0];

  always_comb begin
    state_d    = state_q;
    job_cnt_d  = job_cnt_q;
    done_d     = done_q;
    issue_d    = issue_q;
    out_idx_d  = out_idx_q;
    tick_d     = tick_q;
    rd_vld_d   = 1'b0;
    rd_tag_d   = rd_tag_q;
    found_d    = found_q;
    nxt_vld_d  = nxt_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    nxt_arr_d  = nxt_arr_q;
    twait_d    = twait_q;
    tturn_d    = tturn_q;
    ld_pop_o   = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    waddr      = best_idx_q;
    wdata      = {tick_run, upd_job};

    case (state_q)
      S_LOAD: begin
        if (!ld_empty_i) begin
          ld_pop_o = 1'b1;
          if (ld_data_i.store) begin
            we        = 1'b1;
            waddr     = job_cnt_q[IdxW-1:0];
            wdata     = {TickW'(0), ld_job};
            job_cnt_d = job_cnt_q + 1'b1;
          end
          if (ld_data_i.last) begin
            tick_d    = '0;
            done_d    = '0;
            issue_d   = '0;
            found_d   = 1'b0;
            nxt_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q && live) begin
          if (future) begin
            if (!nxt_vld_q || rd_job.arrival < nxt_arr_q) begin
              nxt_vld_d = 1'b1;
              nxt_arr_d = rd_job.arrival;
            end
          end else if (!found_q || rd_job.prio > best_q.prio ||
                       (rd_job.prio == best_q.prio && rd_job.arrival < best_q.arrival)) begin
            found_d    = 1'b1;
            best_idx_d = rd_tag_q;
            best_d     = rd_job;
          end
        end
        if (issue_q != job_cnt_q) begin
          rd_vld_d = 1'b1;
          rd_tag_d = issue_q[IdxW-1:0];
          issue_d  = issue_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        issue_d   = '0;
        found_d   = 1'b0;
        nxt_vld_d = 1'b0;
        state_d   = S_SCAN;
        if (!found_q) begin
          tick_d = TickW'(nxt_arr_q);
        end else begin
          we     = 1'b1;
          tick_d = tick_run;
          if (new_rem == '0) begin
            done_d = done_q + 1'b1;
            if (done_d == job_cnt_q) begin
              out_idx_d = '0;
              twait_d   = '0;
              tturn_d   = '0;
              state_d   = S_OUT_RD;
            end
          end
        end
      end
      S_OUT_RD: begin
        if (!res_full_i) begin
          state_d = S_OUT_WR;
        end
      end
      S_OUT_WR: begin
        res_push_o = 1'b1;
        twait_d    = (tw_sum > SumW'(pss_pkg::MaxTWait)) ?
                     pss_pkg::TWaitW'(pss_pkg::MaxTWait) : tw_sum[pss_pkg::TWaitW-1:0];
        tturn_d    = (tt_sum > SumW'(pss_pkg::MaxTTurn)) ?
                     pss_pkg::TTurnW'(pss_pkg::MaxTTurn) : tt_sum[pss_pkg::TTurnW-1:0];
        if (num == job_cnt_q) begin
          job_cnt_d = '0;
          done_d    = '0;
          tick_d    = '0;
          state_d   = S_LOAD;
        end else begin
          out_idx_d = num;
          state_d   = S_OUT_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      job_cnt_q <= '0;
      done_q    <= '0;
      issue_q   <= '0;
      out_idx_q <= '0;
      tick_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      nxt_vld_q <= 1'b0;
      twait_q   <= '0;
      tturn_q   <= '0;
    end else begin
      state_q   <= state_d;
      job_cnt_q <= job_cnt_d;
      done_q    <= done_d;
      issue_q   <= issue_d;
      out_idx_q <= out_idx_d;
      tick_q    <= tick_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      nxt_vld_q <= nxt_vld_d;
      twait_q   <= twait_d;
      tturn_q   <= tturn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q   <= rd_tag_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    nxt_arr_q  <= nxt_arr_d;
  end

endmodule

### sv/preemptive_priority_scheduler_core.sv
// Top level of the preemptive priority scheduler.
// Depends on pss_pkg, pss_front, pss_fifo and pss_back.
//
// Usage:
// Input side is a queue: present a job (arrival, burst, priority, last flag)
// with push; it is taken on an edge where push is high and full is low.
// Jobs load at one per cycle while full is low. A zero burst counts as one
// tick; jobs beyond MaxJobs in one set are dropped. The job flagged last
// closes the set. The back end then schedules the set: each pass scans all
// n jobs from the job RAM, decides, and runs the winner up to its completion
// or the next arrival, so a set takes at most about 3n passes, independent
// of burst sizes.
// Results come out in load order, each read then pushed, on a result queue:
// the head is valid while empty is low and is taken with pop. A stalled
// receiver holds the back end once the result queue fills; loading of the
// next set continues into the two-entry queue between front and back.
// Reset empties both queues and the job count; RAM contents are not cleared.
module preemptive_priority_scheduler_core #(
  parameter int MaxJobs = pss_pkg::MaxProcesses
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [pss_pkg::ArrW-1:0]    arrival_time_i,
  input  logic [pss_pkg::BurW-1:0]    burst_length_i,
  input  logic [pss_pkg::PriW-1:0]    job_priority_i,
  input  logic                        last_job_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pss_pkg::NumW-1:0]    job_number_o,
  output logic [pss_pkg::WaitW-1:0]   waiting_time_o,
  output logic [pss_pkg::TurnW-1:0]   turnaround_time_o,
  output logic [pss_pkg::TWaitW-1:0]  total_waiting_o,
  output logic [pss_pkg::TTurnW-1:0]  total_turnaround_o,
  output logic                        last_result_o
);

  localparam int LoadW = $bits(pss_pkg::load_t);
  localparam int ResW  = $bits(pss_pkg::result_t);

  logic             mq_push, mq_full, mq_pop, mq_empty;
  pss_pkg::load_t   mq_in, mq_out;
  logic [LoadW-1:0] mq_out_raw;
  logic             rq_push, rq_full;
  pss_pkg::result_t rq_in, rq_out;
  logic [ResW-1:0]  rq_out_raw;

  assign full   = mq_full;
  assign mq_out = pss_pkg::load_t'(mq_out_raw);
  assign rq_out = pss_pkg::result_t'(rq_out_raw);

  pss_front #(
    .MaxJobs (MaxJobs)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .arrival_i (arrival_time_i),
    .burst_i   (burst_length_i),
    .prio_i    (job_priority_i),
    .last_i    (last_job_i),
    .q_full_i  (mq_full),
    .q_push_o  (mq_push),
    .q_data_o  (mq_in)
  );

  pss_fifo #(
    .Width (LoadW),
    .Depth (pss_pkg::QueueDepth)
  ) u_load_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_in),
    .full_o  (mq_full),
    .pop_i   (mq_pop),
    .data_o  (mq_out_raw),
    .empty_o (mq_empty)
  );

  pss_back #(
    .MaxJobs (MaxJobs)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_data_i  (mq_out),
    .ld_empty_i (mq_empty),
    .ld_pop_o   (mq_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_data_o (rq_in)
  );

  pss_fifo #(
    .Width (ResW),
    .Depth (pss_pkg::QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_out_raw),
    .empty_o (empty)
  );

  assign job_number_o       = rq_out.job_number;
  assign waiting_time_o     = rq_out.waiting;
  assign turnaround_time_o  = rq_out.turnaround;
  assign total_waiting_o    = rq_out.total_waiting;
  assign total_turnaround_o = rq_out.total_turnaround;
  assign last_result_o      = rq_out.last;

endmodule
